// ===== rtl/core/ihq_pkg.sv =====
// shared types and codes for the indexed binary heap queue
// no dependencies
package ihq_pkg;

	localparam int STATUS_BITS = 3;
	localparam int OP_BITS = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CHANGE = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_FULL   = 3'd2,
		ST_ABSENT = 3'd3,
		ST_DUP    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RMK,
		S_LAST,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_C2,
		S_DN_CMP,
		S_PLACE,
		S_FIN,
		S_OUT
	} state_t;

endpackage

// ===== rtl/core/indexed_binary_heap_queue.sv =====
// indexed binary heap priority queue, top level: control sequencer and result register
// depends on ihq_pkg and ihq_heap_ram
//
// use: one command per s_axis transfer (insert, pop best, remove handle, change key),
// one result per command on m_axis. cfg_we writes order_mode (0 largest first,
// 1 smallest first); write it only while the queue is idle, the block does not check.
// each command walks the heap held in a synchronous memory with a single read port:
// a sift up level reads the parent and compares, a sift down level reads the two
// children one after the other and then compares.
// s_axis_tready is high only between commands.
// the result register holds a finished result while the sequencer takes the next
// command; if the receiver stalls, the following command waits at its last step
// until the register is free.
// reset empties the queue and clears order_mode; no memory clearing is needed.
module indexed_binary_heap_queue
	import ihq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int HANDLE_COUNT = 64,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// op, handle, key
	input  logic [((OP_BITS+$clog2(HANDLE_COUNT)+KEY_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status, out_handle, out_key, top_valid, top_handle, top_key, entry_count
	output logic [((STATUS_BITS+2*$clog2(HANDLE_COUNT)+2*KEY_BITS+1+$clog2(CAPACITY+1)+7)/8)*8-1:0]
		m_axis_tdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int HW = $clog2(HANDLE_COUNT);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int PW = CW + 1;
	localparam int EW = HW + KEY_BITS;
	localparam int OW = ((STATUS_BITS+2*HW+2*KEY_BITS+1+CW+7)/8)*8;
	localparam int RW = STATUS_BITS + 2*HW + 2*KEY_BITS + 1 + CW;

	state_t state_q, state_d;

	op_t op_q;
	logic [HW-1:0] h_q;
	logic [KEY_BITS-1:0] key_q;
	logic mode_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] p_q;
	logic [HW-1:0] mh_q, c1h_q;
	logic [KEY_BITS-1:0] mk_q, c1k_q;
	logic moved_q, has2_q;
	status_t status_q;
	logic [HW-1:0] oh_q;
	logic [KEY_BITS-1:0] ok_q;
	logic [HANDLE_COUNT-1:0] queued_q;
	logic out_valid_q;
	logic [RW-1:0] out_q;

	logic slot_we, hs_we;
	logic [AW-1:0] slot_waddr, slot_raddr;
	logic [EW-1:0] slot_wdata, slot_rdata;
	logic [HW-1:0] hs_waddr, hs_raddr;
	logic [AW-1:0] hs_wdata, hs_rdata;

	logic [OP_BITS-1:0] in_op;
	logic [HW-1:0] in_h;
	logic [KEY_BITS-1:0] in_key;
	logic [HW-1:0] rd_h;
	logic [KEY_BITS-1:0] rd_k;
	logic [PW-1:0] p2;
	logic h_ok, hs_ok, take_c2, up_swap, dn_swap, last_fin, out_free;
	logic [HW-1:0] ch;
	logic [KEY_BITS-1:0] ck;
	logic [PW-1:0] cidx;

	function automatic logic worse(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b,
			input logic mode);
		worse = mode ? (a > b) : (a < b);
	endfunction

	assign in_op = s_axis_tdata[OP_BITS-1:0];
	assign in_h = s_axis_tdata[OP_BITS+HW-1:OP_BITS];
	assign in_key = s_axis_tdata[OP_BITS+HW+KEY_BITS-1:OP_BITS+HW];
	assign rd_h = slot_rdata[EW-1:KEY_BITS];
	assign rd_k = slot_rdata[KEY_BITS-1:0];
	assign p2 = PW'(p_q << 1);
	assign h_ok = (32'(h_q) < HANDLE_COUNT);
	assign hs_ok = h_ok && queued_q[h_q] && (CW'(hs_rdata) < count_q);
	assign take_c2 = has2_q && worse(c1k_q, rd_k, mode_q);
	assign ch = take_c2 ? rd_h : c1h_q;
	assign ck = take_c2 ? rd_k : c1k_q;
	assign cidx = take_c2 ? PW'(p2 + PW'(1)) : p2;
	assign up_swap = worse(rd_k, mk_q, mode_q);
	assign dn_swap = worse(mk_q, ck, mode_q);
	assign last_fin = (p_q > PW'(count_q - CW'(1)));
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = OW'(out_q);

	ihq_heap_ram #(
		.CAPACITY(CAPACITY),
		.HANDLE_COUNT(HANDLE_COUNT),
		.KEY_BITS(KEY_BITS)
	) u_ram (
		.clk(clk),
		.slot_we(slot_we),
		.slot_waddr(slot_waddr),
		.slot_wdata(slot_wdata),
		.slot_raddr(slot_raddr),
		.slot_rdata(slot_rdata),
		.hs_we(hs_we),
		.hs_waddr(hs_waddr),
		.hs_wdata(hs_wdata),
		.hs_raddr(hs_raddr),
		.hs_rdata(hs_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid) state_d = S_DEC;
			S_DEC: begin
				case (op_q)
					OP_INSERT: begin
						if (!h_ok || queued_q[h_q] || 32'(count_q) >= CAPACITY) state_d = S_FIN;
						else state_d = S_UP_RD;
					end
					OP_POP: state_d = (count_q == '0) ? S_FIN : S_LAST;
					OP_REMOVE: state_d = hs_ok ? S_RMK : S_FIN;
					OP_CHANGE: state_d = hs_ok ? S_UP_RD : S_FIN;
					default: state_d = S_FIN;
				endcase
			end
			S_RMK: state_d = S_LAST;
			S_LAST: begin
				if (last_fin) state_d = S_FIN;
				else if (op_q == OP_POP) state_d = S_DN_RD;
				else state_d = S_UP_RD;
			end
			S_UP_RD: begin
				if (p_q != PW'(1)) state_d = S_UP_CMP;
				else if (op_q == OP_INSERT || moved_q) state_d = S_PLACE;
				else state_d = S_DN_RD;
			end
			S_UP_CMP: begin
				if (up_swap) state_d = S_UP_RD;
				else if (op_q == OP_INSERT || moved_q) state_d = S_PLACE;
				else state_d = S_DN_RD;
			end
			S_DN_RD: state_d = (p2 <= PW'(count_q)) ? S_DN_C2 : S_PLACE;
			S_DN_C2: state_d = S_DN_CMP;
			S_DN_CMP: state_d = dn_swap ? S_DN_RD : S_PLACE;
			S_PLACE: state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		slot_we = 1'b0;
		slot_waddr = AW'(p_q - PW'(1));
		slot_wdata = {mh_q, mk_q};
		slot_raddr = '0;
		hs_we = 1'b0;
		hs_waddr = mh_q;
		hs_wdata = AW'(p_q - PW'(1));
		hs_raddr = h_q;
		case (state_q)
			S_IDLE: hs_raddr = in_h;
			S_DEC: begin
				if (op_q == OP_POP) slot_raddr = AW'(count_q - CW'(1));
				else slot_raddr = hs_rdata;
			end
			S_RMK: slot_raddr = AW'(count_q - CW'(1));
			S_UP_RD: slot_raddr = AW'((p_q >> 1) - PW'(1));
			S_UP_CMP: begin
				slot_we = up_swap;
				slot_wdata = slot_rdata;
				hs_we = up_swap;
				hs_waddr = rd_h;
			end
			S_DN_RD: slot_raddr = AW'(p2 - PW'(1));
			S_DN_C2: slot_raddr = AW'(p2);
			S_DN_CMP: begin
				slot_we = dn_swap;
				slot_wdata = {ch, ck};
				hs_we = dn_swap;
				hs_waddr = ch;
			end
			S_PLACE: begin
				slot_we = 1'b1;
				hs_we = 1'b1;
			end
			default: slot_raddr = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 1'b0;
			count_q <= '0;
			queued_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mode_q <= cfg_wdata;
			if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_DEC: begin
					if (op_q == OP_INSERT && state_d == S_UP_RD) begin
						count_q <= count_q + CW'(1);
						queued_q[h_q] <= 1'b1;
					end
					if (op_q == OP_POP && state_d == S_LAST) queued_q[rd_h] <= 1'b0;
				end
				S_RMK: queued_q[h_q] <= 1'b0;
				S_LAST: count_q <= count_q - CW'(1);
				S_OUT: if (out_free) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// command payload and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= op_t'(in_op);
				h_q <= in_h;
				key_q <= in_key;
				status_q <= ST_OK;
				oh_q <= '0;
				ok_q <= '0;
				moved_q <= 1'b0;
			end
			S_DEC: begin
				case (op_q)
					OP_INSERT: begin
						if (!h_ok) status_q <= ST_ABSENT;
						else if (queued_q[h_q]) status_q <= ST_DUP;
						else if (32'(count_q) >= CAPACITY) status_q <= ST_FULL;
						mh_q <= h_q;
						mk_q <= key_q;
						p_q <= PW'(count_q) + PW'(1);
					end
					OP_POP: begin
						if (count_q == '0) status_q <= ST_EMPTY;
						else begin
							oh_q <= rd_h;
							ok_q <= rd_k;
						end
						p_q <= PW'(1);
					end
					default: begin
						if (!hs_ok) status_q <= ST_ABSENT;
						else if (op_q == OP_REMOVE) oh_q <= h_q;
						mh_q <= h_q;
						mk_q <= key_q;
						p_q <= PW'(hs_rdata) + PW'(1);
					end
				endcase
			end
			S_RMK: ok_q <= rd_k;
			S_LAST: begin
				mh_q <= rd_h;
				mk_q <= rd_k;
			end
			S_UP_CMP: begin
				if (up_swap) begin
					p_q <= p_q >> 1;
					moved_q <= 1'b1;
				end
			end
			S_DN_C2: begin
				c1h_q <= rd_h;
				c1k_q <= rd_k;
				has2_q <= (p2 < PW'(count_q));
			end
			S_DN_CMP: if (dn_swap) p_q <= cidx;
			S_OUT: begin
				if (out_free) begin
					out_q <= {count_q,
						(count_q != '0) ? rd_k : {KEY_BITS{1'b0}},
						(count_q != '0) ? rd_h : {HW{1'b0}},
						(count_q != '0),
						ok_q, oh_q, status_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/ihq_heap_ram.sv =====
// heap slot memory (handle and key by slot) and handle to slot memory
// depends on nothing; one write and one registered read per memory per cycle
module ihq_heap_ram #(
	parameter int CAPACITY = 64,
	parameter int HANDLE_COUNT = 64,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic slot_we,
	input  logic [$clog2(CAPACITY)-1:0] slot_waddr,
	input  logic [$clog2(HANDLE_COUNT)+KEY_BITS-1:0] slot_wdata,
	input  logic [$clog2(CAPACITY)-1:0] slot_raddr,
	output logic [$clog2(HANDLE_COUNT)+KEY_BITS-1:0] slot_rdata,
	input  logic hs_we,
	input  logic [$clog2(HANDLE_COUNT)-1:0] hs_waddr,
	input  logic [$clog2(CAPACITY)-1:0] hs_wdata,
	input  logic [$clog2(HANDLE_COUNT)-1:0] hs_raddr,
	output logic [$clog2(CAPACITY)-1:0] hs_rdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int HW = $clog2(HANDLE_COUNT);

	logic [HW+KEY_BITS-1:0] slot_mem [CAPACITY];
	logic [AW-1:0] hs_mem [HANDLE_COUNT];

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rdata <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_mem[hs_waddr] <= hs_wdata;
		end
		hs_rdata <= hs_mem[hs_raddr];
	end

endmodule
